[rtl/core/rgbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rgbc_pkg;

    // Field and datapath sizes
    localparam int COUNT_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int QUO_W          = 16;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STG   = QUO_W / DIV_STAGES;
    localparam int RATIO_SCALE    = 100;
    localparam int SCALE_W        = 7;
    localparam int BOUND_W        = 8;

    // Colors
    localparam int NUM_COLORS  = 6;
    localparam int COLOR_W     = 3;
    localparam int CLIP_STRIDE = 48;

    localparam logic [COLOR_W-1:0] COLOR_BLUE   = 3'd0;
    localparam logic [COLOR_W-1:0] COLOR_PINK   = 3'd1;
    localparam logic [COLOR_W-1:0] COLOR_PURPLE = 3'd2;
    localparam logic [COLOR_W-1:0] COLOR_ORANGE = 3'd3;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 3'd4;
    localparam logic [COLOR_W-1:0] COLOR_WHITE  = 3'd5;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_BASE = 1'b1;

    localparam logic [FIELD_W-1:0] MIN_COUNT_RST  = 16'd80;
    localparam logic [FIELD_W-1:0] SOUND_BASE_RST = 16'd2064;

    // Ratio windows in hundredths, all bounds exclusive
    typedef struct packed {
        logic [BOUND_W-1:0] rb_lo;
        logic [BOUND_W-1:0] rb_hi;
        logic [BOUND_W-1:0] rg_lo;
        logic [BOUND_W-1:0] rg_hi;
    } window_t;

    localparam window_t WINDOWS [NUM_COLORS] = '{
        '{8'd76,  8'd80,  8'd83,  8'd88},   // blue
        '{8'd103, 8'd108, 8'd118, 8'd123},  // pink
        '{8'd86,  8'd89,  8'd100, 8'd103},  // purple
        '{8'd152, 8'd163, 8'd146, 8'd155},  // orange
        '{8'd120, 8'd126, 8'd89,  8'd96},   // yellow
        '{8'd89,  8'd93,  8'd95,  8'd98}    // white
    };

    // Divider result: saturated floor quotient plus nonzero-remainder flag
    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic             rem_nz;
    } ratio_t;

    // 100*num/den > lo  <=>  q > lo, or q == lo with a remainder
    function automatic logic above_lo(input ratio_t r, input logic [BOUND_W-1:0] lo);
        return (r.quo > QUO_W'(lo)) || ((r.quo == QUO_W'(lo)) && r.rem_nz);
    endfunction

    // 100*num/den < hi  <=>  q < hi
    function automatic logic below_hi(input ratio_t r, input logic [BOUND_W-1:0] hi);
        return r.quo < QUO_W'(hi);
    endfunction

endpackage

`default_nettype wire

[rtl/core/rgb_ratio_color_classifier.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_red_count, s_green_count, s_blue_count
// m_        out        m_valid / m_ready    m_detected, m_matched, m_color_index,
//                                           m_sound_address, m_ratio_rb, m_ratio_rg
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One reading per cycle while the pipeline is not stalled; each reading passes the front
// stage, the two ratio dividers (four quotient bits per stage) and the output register.
// Reset clears all valid bits and loads min_count = 80, sound_base = 2064.
// A stall on m_ready holds the full stages; empty stages still fill, so s_ready
// drops only when every stage holds an item.
// cfg_ready is always high.

module rgb_ratio_color_classifier #(
    parameter int COUNT_BITS = rgbc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [rgbc_pkg::FIELD_W-1:0]        s_red_count,
    input  wire logic [rgbc_pkg::FIELD_W-1:0]        s_green_count,
    input  wire logic [rgbc_pkg::FIELD_W-1:0]        s_blue_count,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_detected,
    output logic                                     m_matched,
    output logic      [rgbc_pkg::COLOR_W-1:0]        m_color_index,
    output logic      [rgbc_pkg::FIELD_W-1:0]        m_sound_address,
    output logic      [rgbc_pkg::FIELD_W-1:0]        m_ratio_rb,
    output logic      [rgbc_pkg::FIELD_W-1:0]        m_ratio_rg,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rgbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rgbc_pkg::FIELD_W-1:0]        cfg_data
);
    import rgbc_pkg::*;

    localparam int NUM_W = COUNT_BITS + SCALE_W;
    localparam int NSTG  = DIV_STAGES + 2;

    logic [NSTG-1:0]       vld_reg;
    logic [NSTG-1:0]       vld_next;
    logic [NSTG-1:0]       stage_en;

    logic [FIELD_W-1:0]    min_count_reg;
    logic [FIELD_W-1:0]    sound_base_reg;

    logic [NUM_W-1:0]      num;
    logic [COUNT_BITS-1:0] den_b;
    logic [COUNT_BITS-1:0] den_g;
    logic                  det_front;
    logic                  det_pipe_reg [DIV_STAGES];
    ratio_t                rb_res;
    ratio_t                rg_res;

    // Stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        stage_en[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (stage_en[0]) begin
            vld_next[0] = s_valid;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (stage_en[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = vld_reg[NSTG-1];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_count_reg  <= MIN_COUNT_RST;
            sound_base_reg <= SOUND_BASE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_COUNT:  min_count_reg  <= cfg_data;
                CFG_SOUND_BASE: sound_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 0: mask, detect, numerator
    rgbc_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk        (aclk),
        .en          (stage_en[0]),
        .red_count   (s_red_count),
        .green_count (s_green_count),
        .blue_count  (s_blue_count),
        .min_count   (min_count_reg),
        .num         (num),
        .den_b       (den_b),
        .den_g       (den_g),
        .detected    (det_front)
    );

    // Stages 1..DIV_STAGES: both ratios in parallel
    rgbc_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div_rb (
        .aclk (aclk),
        .en   (stage_en[DIV_STAGES:1]),
        .num  (num),
        .den  (den_b),
        .res  (rb_res)
    );

    rgbc_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div_rg (
        .aclk (aclk),
        .en   (stage_en[DIV_STAGES:1]),
        .num  (num),
        .den  (den_g),
        .res  (rg_res)
    );

    // Detect flag travels alongside the dividers
    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            det_pipe_reg[0] <= det_front;
        end
        for (int s = 1; s < DIV_STAGES; s++) begin
            if (stage_en[s+1]) begin
                det_pipe_reg[s] <= det_pipe_reg[s-1];
            end
        end
    end

    // Last stage: window match and output register
    rgbc_class u_class (
        .aclk          (aclk),
        .en            (stage_en[NSTG-1]),
        .det           (det_pipe_reg[DIV_STAGES-1]),
        .rb            (rb_res),
        .rg            (rg_res),
        .sound_base    (sound_base_reg),
        .detected      (m_detected),
        .matched       (m_matched),
        .color_index   (m_color_index),
        .sound_address (m_sound_address),
        .ratio_rb      (m_ratio_rb),
        .ratio_rg      (m_ratio_rg)
    );

endmodule

`default_nettype wire

[rtl/core/rgbc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgbc_front #(
    parameter int COUNT_BITS = rgbc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     en,
    input  wire logic [rgbc_pkg::FIELD_W-1:0]             red_count,
    input  wire logic [rgbc_pkg::FIELD_W-1:0]             green_count,
    input  wire logic [rgbc_pkg::FIELD_W-1:0]             blue_count,
    input  wire logic [rgbc_pkg::FIELD_W-1:0]             min_count,
    output logic      [COUNT_BITS+rgbc_pkg::SCALE_W-1:0]  num,
    output logic      [COUNT_BITS-1:0]                    den_b,
    output logic      [COUNT_BITS-1:0]                    den_g,
    output logic                                          detected
);
    import rgbc_pkg::*;

    localparam int NUM_W = COUNT_BITS + SCALE_W;
    localparam int DW    = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

    logic [COUNT_BITS-1:0] r_c;
    logic [COUNT_BITS-1:0] g_c;
    logic [COUNT_BITS-1:0] b_c;
    logic                  det_next;
    logic [NUM_W-1:0]      num_next;

    logic [NUM_W-1:0]      num_reg;
    logic [COUNT_BITS-1:0] den_b_reg;
    logic [COUNT_BITS-1:0] den_g_reg;
    logic                  det_reg;

    // Keep the low COUNT_BITS of each count
    assign r_c = COUNT_BITS'(red_count);
    assign g_c = COUNT_BITS'(green_count);
    assign b_c = COUNT_BITS'(blue_count);

    // Detection: any channel at or above the threshold
    assign det_next = (DW'(r_c) >= DW'(min_count)) || (DW'(g_c) >= DW'(min_count))
                   || (DW'(b_c) >= DW'(min_count));

    // Shared numerator 100*red
    assign num_next = NUM_W'(r_c) * NUM_W'(RATIO_SCALE);

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg   <= num_next;
            den_b_reg <= b_c;
            den_g_reg <= g_c;
            det_reg   <= det_next;
        end
    end

    assign num      = num_reg;
    assign den_b    = den_b_reg;
    assign den_g    = den_g_reg;
    assign detected = det_reg;

endmodule

`default_nettype wire

[rtl/core/rgbc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgbc_div #(
    parameter int COUNT_BITS = rgbc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic [rgbc_pkg::DIV_STAGES-1:0]          en,
    input  wire logic [COUNT_BITS+rgbc_pkg::SCALE_W-1:0]  num,
    input  wire logic [COUNT_BITS-1:0]                    den,
    output rgbc_pkg::ratio_t                              res
);
    import rgbc_pkg::*;

    localparam int NUM_W = COUNT_BITS + SCALE_W;
    localparam int REM_W = COUNT_BITS + QUO_W;

    logic [REM_W-1:0]      rem_reg [DIV_STAGES];
    logic [COUNT_BITS-1:0] den_reg [DIV_STAGES];
    logic [QUO_W-1:0]      quo_reg [DIV_STAGES];
    logic                  sat_reg [DIV_STAGES];

    // Restoring division, BITS_PER_STG quotient bits per stage
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
        logic [REM_W-1:0]      rem_in;
        logic [COUNT_BITS-1:0] den_in;
        logic [QUO_W-1:0]      quo_in;
        logic                  sat_in;
        logic [REM_W-1:0]      rem_c;
        logic [QUO_W-1:0]      quo_c;
        logic [REM_W-1:0]      trial;

        if (s == 0) begin : g_first
            // Quotient overflows 16 bits (or den is zero): saturate
            assign rem_in = REM_W'(num);
            assign den_in = den;
            assign quo_in = '0;
            assign sat_in = REM_W'(num) >= (REM_W'(den) << QUO_W);
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign sat_in = sat_reg[s-1];
        end

        always_comb begin
            rem_c = rem_in;
            quo_c = quo_in;
            trial = '0;
            for (int b = 0; b < BITS_PER_STG; b++) begin
                trial = REM_W'(den_in) << (QUO_W - 1 - s * BITS_PER_STG - b);
                if (rem_c >= trial) begin
                    rem_c = rem_c - trial;
                    quo_c[QUO_W-1-s*BITS_PER_STG-b] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[s]) begin
                rem_reg[s] <= rem_c;
                den_reg[s] <= den_in;
                quo_reg[s] <= quo_c;
                sat_reg[s] <= sat_in;
            end
        end
    end

    assign res.quo    = sat_reg[DIV_STAGES-1] ? '1 : quo_reg[DIV_STAGES-1];
    assign res.rem_nz = |rem_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/core/rgbc_class.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgbc_class (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic                                det,
    input  wire rgbc_pkg::ratio_t                    rb,
    input  wire rgbc_pkg::ratio_t                    rg,
    input  wire logic [rgbc_pkg::FIELD_W-1:0]        sound_base,
    output logic                                     detected,
    output logic                                     matched,
    output logic      [rgbc_pkg::COLOR_W-1:0]        color_index,
    output logic      [rgbc_pkg::FIELD_W-1:0]        sound_address,
    output logic      [rgbc_pkg::FIELD_W-1:0]        ratio_rb,
    output logic      [rgbc_pkg::FIELD_W-1:0]        ratio_rg
);
    import rgbc_pkg::*;

    logic [NUM_COLORS-1:0] hit;
    logic                  match_c;
    logic [COLOR_W-1:0]    idx_c;
    logic [FIELD_W-1:0]    ofs_c;

    logic                  det_reg;
    logic                  match_reg;
    logic [COLOR_W-1:0]    idx_reg;
    logic [FIELD_W-1:0]    addr_reg;
    logic [FIELD_W-1:0]    rb_reg;
    logic [FIELD_W-1:0]    rg_reg;

    // Window tests, all in parallel
    always_comb begin
        for (int k = 0; k < NUM_COLORS; k++) begin
            hit[k] = above_lo(rb, WINDOWS[k].rb_lo) && below_hi(rb, WINDOWS[k].rb_hi)
                  && above_lo(rg, WINDOWS[k].rg_lo) && below_hi(rg, WINDOWS[k].rg_hi);
        end
    end

    // First window in list order wins
    always_comb begin
        match_c = 1'b0;
        idx_c   = '0;
        ofs_c   = '0;
        for (int k = NUM_COLORS - 1; k >= 0; k--) begin
            if (hit[k]) begin
                match_c = 1'b1;
                idx_c   = COLOR_W'(k);
                ofs_c   = FIELD_W'(CLIP_STRIDE * k);
            end
        end
    end

    // Output register; all zero when nothing detected
    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg   <= det;
            match_reg <= det && match_c;
            idx_reg   <= (det && match_c) ? idx_c : '0;
            addr_reg  <= (det && match_c) ? sound_base + ofs_c : '0;
            rb_reg    <= det ? rb.quo : '0;
            rg_reg    <= det ? rg.quo : '0;
        end
    end

    assign detected      = det_reg;
    assign matched       = match_reg;
    assign color_index   = idx_reg;
    assign sound_address = addr_reg;
    assign ratio_rb      = rb_reg;
    assign ratio_rg      = rg_reg;

endmodule

`default_nettype wire

[rtl/core/rgbc_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgbc_chk (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic                                m_detected,
    input wire logic                                m_matched,
    input wire logic [rgbc_pkg::COLOR_W-1:0]        m_color_index,
    input wire logic [rgbc_pkg::FIELD_W-1:0]        m_sound_address,
    input wire logic [rgbc_pkg::FIELD_W-1:0]        m_ratio_rb,
    input wire logic [rgbc_pkg::FIELD_W-1:0]        m_ratio_rg
);
    import rgbc_pkg::*;

    // Pipeline empties on reset
    a_rst_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sound_address)
                                && $stable(m_ratio_rb) && $stable(m_ratio_rg))
        else $error("stalled result changed");

    // Nothing detected: match flag, ratios and address zero
    a_undet_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_detected |-> !m_matched && m_ratio_rb == '0 && m_ratio_rg == '0
                                   && m_sound_address == '0)
        else $error("undetected reading carries data");

    // No match: index and address zero
    a_nomatch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_matched |-> m_color_index == COLOR_BLUE && m_sound_address == '0)
        else $error("unmatched reading carries color");

    // A blue match lies inside the blue window
    a_blue_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_matched && m_color_index == COLOR_BLUE |->
            m_ratio_rb >= 16'd76 && m_ratio_rb <= 16'd79
            && m_ratio_rg >= 16'd83 && m_ratio_rg <= 16'd87)
        else $error("blue match outside its window");

endmodule

bind rgb_ratio_color_classifier rgbc_chk u_rgbc_chk (.*);

`default_nettype wire

[tb/sv/rgb_ratio_color_classifier_test.sv]
`timescale 1ns / 1ps

module rgb_ratio_color_classifier_test;
    import rgbc_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int DRAIN_CYCLES = 12;    // margin beyond the pipeline depth
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int STALL_LIMIT  = 3000;  // cycles without any transfer
    localparam int MAX_REPORTS  = 10;

    // One classification, field order matches the output ports
    typedef struct packed {
        logic               detected;
        logic               matched;
        logic [COLOR_W-1:0] color_index;
        logic [FIELD_W-1:0] sound_address;
        logic [FIELD_W-1:0] ratio_rb;
        logic [FIELD_W-1:0] ratio_rg;
    } reading_result_t;

    typedef struct packed {
        logic [7:0] rb_lo;
        logic [7:0] rb_hi;
        logic [7:0] rg_lo;
        logic [7:0] rg_hi;
    } ratio_window_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [FIELD_W-1:0]   s_red_count     = '0;
    logic [FIELD_W-1:0]   s_green_count   = '0;
    logic [FIELD_W-1:0]   s_blue_count    = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_detected;
    logic                 m_matched;
    logic [COLOR_W-1:0]   m_color_index;
    logic [FIELD_W-1:0]   m_sound_address;
    logic [FIELD_W-1:0]   m_ratio_rb;
    logic [FIELD_W-1:0]   m_ratio_rg;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [FIELD_W-1:0]   cfg_data        = '0;

    // Register mirror
    logic [FIELD_W-1:0] cur_min_count  = MIN_COUNT_RST;
    logic [FIELD_W-1:0] cur_sound_base = SOUND_BASE_RST;

    reading_result_t pending_results[$];
    reading_result_t got_result;
    reading_result_t want_result;

    rx_mode_t rx_mode   = RX_RANDOM;
    logic     hold_req  = 1'b0;
    int       hold_left = 0;
    int       rx_cycle  = 0;

    int mismatches      = 0;
    int readings_sent   = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int undetected_seen = 0;
    int unmatched_seen  = 0;
    int color_hits[NUM_COLORS];
    int idle_run        = 0;

    rgb_ratio_color_classifier u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red_count     (s_red_count),
        .s_green_count   (s_green_count),
        .s_blue_count    (s_blue_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_detected      (m_detected),
        .m_matched       (m_matched),
        .m_color_index   (m_color_index),
        .m_sound_address (m_sound_address),
        .m_ratio_rb      (m_ratio_rb),
        .m_ratio_rg      (m_ratio_rg),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ---------------------------------------------------------------
    // Classifier prediction
    // ---------------------------------------------------------------

    // Open windows in hundredths: R/B range, then R/G range
    function automatic ratio_window_t window_of(input logic [COLOR_W-1:0] color);
        case (color)
            COLOR_BLUE:   return '{8'd76,  8'd80,  8'd83,  8'd88};
            COLOR_PINK:   return '{8'd103, 8'd108, 8'd118, 8'd123};
            COLOR_PURPLE: return '{8'd86,  8'd89,  8'd100, 8'd103};
            COLOR_ORANGE: return '{8'd152, 8'd163, 8'd146, 8'd155};
            COLOR_YELLOW: return '{8'd120, 8'd126, 8'd89,  8'd96};
            default:      return '{8'd89,  8'd93,  8'd95,  8'd98};
        endcase
    endfunction

    // floor(100*num/den), saturated; all ones for a zero denominator
    function automatic logic [FIELD_W-1:0] ratio_hundredths(input logic [63:0] num,
                                                            input logic [63:0] den);
        logic [63:0] q;
        if (den == 0) return '1;
        q = (64'd100 * num) / den;
        return (q > 64'd65535) ? '1 : q[FIELD_W-1:0];
    endfunction

    // lo/100 < num/den < hi/100, exact cross-multiplication
    function automatic logic strictly_between(input logic [63:0] num, input logic [63:0] den,
                                              input logic [7:0] lo, input logic [7:0] hi);
        if (den == 0) return 1'b0;
        return (64'd100 * num > 64'(lo) * den) && (64'd100 * num < 64'(hi) * den);
    endfunction

    function automatic reading_result_t classify_reading(input logic [FIELD_W-1:0] r,
                                                         input logic [FIELD_W-1:0] g,
                                                         input logic [FIELD_W-1:0] b);
        reading_result_t res;
        ratio_window_t   w;
        logic [63:0]     addr;
        res = '0;
        if (r < cur_min_count && g < cur_min_count && b < cur_min_count) return res;
        res.detected = 1'b1;
        res.ratio_rb = ratio_hundredths(r, b);
        res.ratio_rg = ratio_hundredths(r, g);
        // first matching window wins
        for (int k = 0; k < NUM_COLORS; k++) begin
            w = window_of(COLOR_W'(k));
            if (!res.matched && strictly_between(r, b, w.rb_lo, w.rb_hi)
                && strictly_between(r, g, w.rg_lo, w.rg_hi)) begin
                res.matched       = 1'b1;
                res.color_index   = COLOR_W'(k);
                addr              = 64'(cur_sound_base) + 64'(CLIP_STRIDE) * k;
                res.sound_address = addr[FIELD_W-1:0];
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    task automatic send_reading(input logic [FIELD_W-1:0] r, input logic [FIELD_W-1:0] g,
                                input logic [FIELD_W-1:0] b);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_red_count   <= r;
        s_green_count <= g;
        s_blue_count  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(classify_reading(r, g, b));
        readings_sent++;
    endtask

    // drop valid and keep it low; n sets the idle length (n >= 1)
    task automatic idle_sender(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // stop sending and wait until every result is back
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [FIELD_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_MIN_COUNT) cur_min_count = value;
        else cur_sound_base = value;
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(input logic [FIELD_W-1:0] min_count,
                                 input logic [FIELD_W-1:0] sound_base);
        write_register(CFG_MIN_COUNT, min_count);
        write_register(CFG_SOUND_BASE, sound_base);
    endtask

    // a count close to the detection threshold
    function automatic logic [FIELD_W-1:0] near_threshold();
        int t;
        t = int'(cur_min_count) - 2 + int'($urandom_range(0, 3));
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        return FIELD_W'(t);
    endfunction

    // mostly readings aimed into a color window, the rest noise and corner values
    task automatic make_reading(output logic [FIELD_W-1:0] r, output logic [FIELD_W-1:0] g,
                                output logic [FIELD_W-1:0] b);
        int unsigned   kind;
        ratio_window_t w;
        logic [63:0]   rv, gv, bv;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            w  = window_of(COLOR_W'($urandom_range(0, NUM_COLORS - 1)));
            bv = $urandom_range(1, 1 << $urandom_range(4, 14));
            rv = bv * (64'(w.rb_lo) * 100 + $urandom_range(0, (w.rb_hi - w.rb_lo) * 100))
                 / 10000;
            gv = rv * 10000
                 / (64'(w.rg_lo) * 100 + $urandom_range(0, (w.rg_hi - w.rg_lo) * 100));
            r  = rv[FIELD_W-1:0];
            g  = gv[FIELD_W-1:0];
            b  = bv[FIELD_W-1:0];
        end else if (kind < 75) begin
            r = FIELD_W'($urandom_range(0, 65535));
            g = FIELD_W'($urandom_range(0, 65535));
            b = FIELD_W'($urandom_range(0, 65535));
        end else if (kind < 88) begin
            r = near_threshold();
            g = near_threshold();
            b = near_threshold();
        end else begin
            r = FIELD_W'($urandom_range(0, 65535));
            g = $urandom_range(0, 1) ? '0 : FIELD_W'($urandom_range(0, 65535));
            b = $urandom_range(0, 1) ? '0 : FIELD_W'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) r = '1;
        end
    endtask

    // bursts of random length with random gaps between them
    task automatic send_random_readings(input int n, input int max_gap);
        int                 burst;
        int                 gap;
        logic [FIELD_W-1:0] r, g, b;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap   = $urandom_range(0, max_gap);
                if (gap > 0) idle_sender(gap);
            end
            make_reading(r, g, b);
            send_reading(r, g, b);
            burst--;
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: stall pattern per mode, plus a long hold-off on request
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  m_ready <= 1'b1;
                RX_RANDOM:  m_ready <= ($urandom_range(0, 99) < 70);
                RX_PATTERN: m_ready <= ((rx_cycle % 7) < 4);
                default:    m_ready <= ($urandom_range(0, 99) < 20);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result check against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_result = {m_detected, m_matched, m_color_index, m_sound_address,
                          m_ratio_rb, m_ratio_rg};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: det=%0b match=%0b color=%0d",
                             $realtime, got_result.detected, got_result.matched,
                             got_result.color_index);
            end else begin
                want_result = pending_results.pop_front();
                results_checked++;
                if (!want_result.detected) undetected_seen++;
                else if (want_result.matched) color_hits[want_result.color_index]++;
                else unmatched_seen++;
                if (got_result !== want_result) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: mismatch det %0b/%0b match %0b/%0b color %0d/%0d ",
                                  "addr %0d/%0d rb %0d/%0d rg %0d/%0d (expected/actual)"},
                                 $realtime,
                                 want_result.detected, got_result.detected,
                                 want_result.matched, got_result.matched,
                                 want_result.color_index, got_result.color_index,
                                 want_result.sound_address, got_result.sound_address,
                                 want_result.ratio_rb, got_result.ratio_rb,
                                 want_result.ratio_rg, got_result.ratio_rg);
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial begin
        while (idle_run < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_results.size());
        $display("rgb_ratio_color_classifier_test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // all channels below, and exactly at, the threshold
    task automatic test_detection_threshold();
        send_reading(16'd0, 16'd0, 16'd0);
        send_reading(16'd79, 16'd79, 16'd79);
        send_reading(16'd80, 16'd0, 16'd0);
        send_reading(16'd0, 16'd80, 16'd0);
        send_reading(16'd0, 16'd0, 16'd80);
    endtask

    // blue or green zero: no window can match, ratio saturates; red zero gives zero ratios
    task automatic test_zero_denominators();
        send_reading(16'd500, 16'd0, 16'd300);
        send_reading(16'd500, 16'd300, 16'd0);
        send_reading(16'd0, 16'd500, 16'd500);
    endtask

    task automatic test_ratio_saturation();
        send_reading(16'hFFFF, 16'd1, 16'd1);
        send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    // one reading inside each window
    task automatic test_each_color();
        send_reading(16'd780, 16'd920, 16'd1000);    // blue
        send_reading(16'd1050, 16'd875, 16'd1000);   // pink
        send_reading(16'd870, 16'd861, 16'd1000);    // purple
        send_reading(16'd1550, 16'd1033, 16'd1000);  // orange
        send_reading(16'd1230, 16'd1337, 16'd1000);  // yellow
        send_reading(16'd910, 16'd948, 16'd1000);    // white
    endtask

    // ratios exactly on an open bound, and just inside
    task automatic test_window_bounds();
        send_reading(16'd760, 16'd900, 16'd1000);
        send_reading(16'd800, 16'd940, 16'd1000);
        send_reading(16'd761, 16'd900, 16'd1000);
    endtask

    task automatic test_register_extremes();
        wait_for_results();
        set_registers(16'd0, 16'd65295);
        send_reading(16'd0, 16'd0, 16'd0);
        send_reading(16'd910, 16'd948, 16'd1000);    // white at the top of the address range
        wait_for_results();
        set_registers(16'hFFFF, 16'd0);
        send_reading(16'hFFFE, 16'hFFFE, 16'hFFFE);
        send_reading(16'hFFFF, 16'd0, 16'd0);
        wait_for_results();
    endtask

    // receiver holds off while the sender keeps offering, so the pipe fills
    task automatic test_backpressure();
        logic [FIELD_W-1:0] r, g, b;
        wait_for_results();
        set_registers(MIN_COUNT_RST, SOUND_BASE_RST);
        rx_mode  = RX_ALWAYS;
        hold_req = 1'b1;
        repeat (40) begin
            make_reading(r, g, b);
            send_reading(r, g, b);
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++) begin
            wait_for_results();
            case (p)
                0: begin
                    set_registers(MIN_COUNT_RST, SOUND_BASE_RST);
                    rx_mode = RX_RANDOM;
                end
                1: begin
                    set_registers(FIELD_W'($urandom_range(0, 400)),
                                  FIELD_W'($urandom_range(0, 65295)));
                    rx_mode = RX_PATTERN;
                end
                2: begin
                    set_registers(FIELD_W'($urandom_range(0, 160)), 16'd65295);
                    rx_mode = RX_SPARSE;
                end
                default: begin
                    set_registers(FIELD_W'($urandom_range(0, 1000)), 16'd0);
                    rx_mode = RX_ALWAYS;
                end
            endcase
            // phase 1 runs without sender gaps
            send_random_readings(240, (p == 1) ? 0 : 4 + 5 * p);
            wait_for_results();
            send_random_readings(240, (p == 1) ? 0 : 4 + 5 * p);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_detection_threshold();
        test_zero_denominators();
        test_ratio_saturation();
        test_each_color();
        test_window_bounds();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        rx_mode = RX_ALWAYS;
        wait_for_results();

        $display("covered %0d readings, %0d results checked, %0d register writes",
                 readings_sent, results_checked, reg_writes);
        $display({"colors blue %0d pink %0d purple %0d orange %0d yellow %0d white %0d, ",
                  "%0d undetected, %0d detected without a match"},
                 color_hits[COLOR_BLUE], color_hits[COLOR_PINK], color_hits[COLOR_PURPLE],
                 color_hits[COLOR_ORANGE], color_hits[COLOR_YELLOW], color_hits[COLOR_WHITE],
                 undetected_seen, unmatched_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("rgb_ratio_color_classifier_test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_results.size());
            $display("rgb_ratio_color_classifier_test failed");
        end
        $finish;
    end

endmodule
